// ===== rtl/amwb_pkg.sv =====
// shared constants, types and helper functions for the affine mask warp blend block
// no dependencies

package amwb_pkg;

   localparam int MASK_WIDTH  = 256;
   localparam int MASK_HEIGHT = 256;
   localparam int XW          = $clog2(MASK_WIDTH);
   localparam int YW          = $clog2(MASK_HEIGHT);
   localparam int HALF_W      = (MASK_WIDTH + 1) / 2;
   localparam int HALF_H      = (MASK_HEIGHT + 1) / 2;
   localparam int BANK_DEPTH  = HALF_W * HALF_H;
   localparam int BAW         = $clog2(BANK_DEPTH);
   localparam int NUM_BANKS   = 4;

   localparam logic signed [46:0] ONE_Q16 = 47'sd65536;
   localparam logic signed [46:0] U_MAX   = 47'((MASK_WIDTH - 1) * 65536);
   localparam logic signed [46:0] V_MAX   = 47'((MASK_HEIGHT - 1) * 65536);

   localparam logic [6:0] STRENGTH_MAX = 7'd100;

   typedef enum logic [2:0] {
      CSR_COEF_UX  = 3'd0,
      CSR_COEF_UY  = 3'd1,
      CSR_OFFSET_U = 3'd2,
      CSR_COEF_VX  = 3'd3,
      CSR_COEF_VY  = 3'd4,
      CSR_OFFSET_V = 3'd5,
      CSR_STRENGTH = 3'd6,
      CSR_INTERP   = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic            en;
      logic [1:0]      bank;
      logic [BAW-1:0]  addr;
      logic [31:0]     data;
   } ram_wr_type;

   // a + floor(f * (b - a) / 16384)
   function automatic logic [7:0] lerp14(logic [7:0] a, logic [7:0] b, logic [13:0] f);
      logic signed [8:0]  d;
      logic signed [23:0] p;
      logic signed [9:0]  s;
      d = $signed({1'b0, b}) - $signed({1'b0, a});
      p = $signed({1'b0, f}) * d;
      s = $signed({2'b00, a}) + $signed(p[23:14]);
      return s[7:0];
   endfunction

   // 128 * s / 100 for s up to 100, as 32 * s / 25 by reciprocal
   function automatic logic [7:0] mix_alpha(logic [6:0] strength);
      logic [6:0]  s;
      logic [17:0] p;
      s = (strength > STRENGTH_MAX) ? STRENGTH_MAX : strength;
      p = 18'(s) * 18'd1311;
      return p[17:10];
   endfunction

endpackage

// ===== rtl/amwb_mask_ram.sv =====
// mask store split into four banks by row and column parity, one read per bank a cycle
// depends on amwb_pkg

module amwb_mask_ram (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       en,
   input  amwb_pkg::ram_wr_type                       wr,
   input  logic                                       rd_en,
   input  logic [amwb_pkg::NUM_BANKS-1:0][amwb_pkg::BAW-1:0] rd_addr,
   output logic [amwb_pkg::NUM_BANKS-1:0][31:0]       rd_data
);

   for (genvar b = 0; b < amwb_pkg::NUM_BANKS; b++) begin : g_bank
      logic [31:0] mem [amwb_pkg::BANK_DEPTH];

      always_ff @(posedge clock) begin
         if (en) begin
            if (wr.en && (wr.bank == 2'(b))) begin
               mem[wr.addr] <= wr.data;
            end
            if (rd_en) begin
               rd_data[b] <= mem[rd_addr[b]];
            end
         end
      end
   end

   // one item sits in the access stage, so a load and a sample never share a cycle
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset) !(wr.en && rd_en))
      else $error("mask write and read in the same cycle");

endmodule

// ===== rtl/affine_mask_warp_blend.sv =====
// top level: affine map, banked mask sampling and alpha blend pipeline
// depends on amwb_pkg and amwb_mask_ram

// Takes one request per cycle and returns one pixel per cycle while the output is
// not stalled, through the affine map, the mask bank read, the bilinear lerps and
// the blend. The mask sits in four banks split by row and column parity, so the
// four bilinear neighbors are read in the same cycle. Mask loads (tuser 0) return
// nothing; a mask texel must be loaded before any pixel samples it. Registers must
// be written only while no request is in flight; the block does not enforce it.
module affine_mask_warp_blend (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // pos_x, pos_y, blue, green, red, alpha
   input  logic        req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // out_blue, out_green, out_red
   output logic        rsp_tuser,   // touched
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   localparam int XW  = amwb_pkg::XW;
   localparam int YW  = amwb_pkg::YW;
   localparam int BAW = amwb_pkg::BAW;

   // configuration
   logic signed [31:0] cux_ff, cuy_ff, ou_ff, cvx_ff, cvy_ff, ov_ff;
   logic [6:0]         strength_ff;
   logic               interp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cux_ff      <= 32'sd65536;
         cuy_ff      <= '0;
         ou_ff       <= '0;
         cvx_ff      <= '0;
         cvy_ff      <= 32'sd65536;
         ov_ff       <= '0;
         strength_ff <= amwb_pkg::STRENGTH_MAX;
         interp_ff   <= 1'b0;
      end else if (csr_we) begin
         unique case (amwb_pkg::csr_index_type'(csr_addr))
            amwb_pkg::CSR_COEF_UX:  cux_ff      <= csr_wdata;
            amwb_pkg::CSR_COEF_UY:  cuy_ff      <= csr_wdata;
            amwb_pkg::CSR_OFFSET_U: ou_ff       <= csr_wdata;
            amwb_pkg::CSR_COEF_VX:  cvx_ff      <= csr_wdata;
            amwb_pkg::CSR_COEF_VY:  cvy_ff      <= csr_wdata;
            amwb_pkg::CSR_OFFSET_V: ov_ff       <= csr_wdata;
            amwb_pkg::CSR_STRENGTH: strength_ff <= csr_wdata[6:0];
            amwb_pkg::CSR_INTERP:   interp_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic       advance;
   logic       accept;
   logic [11:0] req_x, req_y;
   assign req_x  = req_tdata[11:0];
   assign req_y  = req_tdata[23:12];
   assign accept = req_tvalid && req_tready;

   // stage 1: products
   logic               s1_valid_ff, s1_kind_ff;
   logic [11:0]        s1_x_ff, s1_y_ff;
   logic [31:0]        s1_pix_ff;
   logic signed [44:0] s1_ux_ff, s1_uy_ff, s1_vx_ff, s1_vy_ff;
   logic signed [44:0] s1_ux_in, s1_uy_in, s1_vx_in, s1_vy_in;

   assign s1_ux_in = cux_ff * $signed({1'b0, req_x});
   assign s1_uy_in = cuy_ff * $signed({1'b0, req_y});
   assign s1_vx_in = cvx_ff * $signed({1'b0, req_x});
   assign s1_vy_in = cvy_ff * $signed({1'b0, req_y});

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_kind_ff <= req_tuser;
         s1_x_ff    <= req_x;
         s1_y_ff    <= req_y;
         s1_pix_ff  <= req_tdata[55:24];
         s1_ux_ff   <= s1_ux_in;
         s1_uy_ff   <= s1_uy_in;
         s1_vx_ff   <= s1_vx_in;
         s1_vy_ff   <= s1_vy_in;
      end
   end

   // stage 2: coordinates, inside test and bank addresses
   logic signed [46:0] u_sum, v_sum;
   logic               in_mask;
   logic [XW-1:0]      x0;
   logic [YW-1:0]      y0;
   logic [13:0]        fx_in, fy_in;
   logic [amwb_pkg::NUM_BANKS-1:0][BAW-1:0] rd_addr_in;
   amwb_pkg::ram_wr_type wr_in;

   assign u_sum = 47'(s1_ux_ff) + 47'(s1_uy_ff) + 47'(ou_ff);
   assign v_sum = 47'(s1_vx_ff) + 47'(s1_vy_ff) + 47'(ov_ff);

   always_comb begin
      if (interp_ff) begin
         in_mask = (u_sum >= amwb_pkg::ONE_Q16) && (u_sum < amwb_pkg::U_MAX) &&
                   (v_sum >= amwb_pkg::ONE_Q16) && (v_sum < amwb_pkg::V_MAX);
         fx_in   = '0;
         fy_in   = '0;
      end else begin
         in_mask = (u_sum > 47'sd0) && (u_sum < amwb_pkg::U_MAX) &&
                   (v_sum > 47'sd0) && (v_sum < amwb_pkg::V_MAX);
         fx_in   = u_sum[15:2];
         fy_in   = v_sum[15:2];
      end
   end

   assign x0 = u_sum[16 +: XW];
   assign y0 = v_sum[16 +: YW];

   // bank index is {row parity, column parity}
   for (genvar b = 0; b < amwb_pkg::NUM_BANKS; b++) begin : g_addr
      logic [XW:0] col;
      logic [YW:0] row;
      assign col = ({1'b0, x0} + (XW+1)'(b[0] != x0[0])) >> 1;
      assign row = ({1'b0, y0} + (YW+1)'(b[1] != y0[0])) >> 1;
      assign rd_addr_in[b] = BAW'(row) * BAW'(amwb_pkg::HALF_W) + BAW'(col);
   end

   always_comb begin
      wr_in.en   = s1_valid_ff && !s1_kind_ff &&
                   (13'(s1_x_ff) < 13'(amwb_pkg::MASK_WIDTH)) &&
                   (13'(s1_y_ff) < 13'(amwb_pkg::MASK_HEIGHT));
      wr_in.bank = {s1_y_ff[0], s1_x_ff[0]};
      wr_in.addr = BAW'(s1_y_ff >> 1) * BAW'(amwb_pkg::HALF_W) + BAW'(s1_x_ff >> 1);
      wr_in.data = s1_pix_ff;
   end

   logic        s2_pix_ff, s2_touch_ff, s2_xp_ff, s2_yp_ff;
   logic [13:0] s2_fx_ff, s2_fy_ff;
   logic [23:0] s2_src_ff;
   logic [amwb_pkg::NUM_BANKS-1:0][BAW-1:0] s2_addr_ff;
   amwb_pkg::ram_wr_type s2_wr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_pix_ff   <= 1'b0;
         s2_wr_ff.en <= 1'b0;
      end else if (advance) begin
         s2_pix_ff   <= s1_valid_ff && s1_kind_ff;
         s2_wr_ff.en <= wr_in.en;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_touch_ff   <= in_mask;
         s2_xp_ff      <= x0[0];
         s2_yp_ff      <= y0[0];
         s2_fx_ff      <= fx_in;
         s2_fy_ff      <= fy_in;
         s2_src_ff     <= s1_pix_ff[23:0];
         s2_addr_ff    <= rd_addr_in;
         s2_wr_ff.bank <= wr_in.bank;
         s2_wr_ff.addr <= wr_in.addr;
         s2_wr_ff.data <= wr_in.data;
      end
   end

   // stage 3: mask banks
   logic [amwb_pkg::NUM_BANKS-1:0][31:0] rd_data;

   amwb_mask_ram u_mask_ram (
      .clock   (clock),
      .reset   (reset),
      .en      (advance),
      .wr      (s2_wr_ff),
      .rd_en   (s2_pix_ff && s2_touch_ff),
      .rd_addr (s2_addr_ff),
      .rd_data (rd_data)
   );

   logic        s3_pix_ff, s3_touch_ff, s3_xp_ff, s3_yp_ff;
   logic [13:0] s3_fx_ff, s3_fy_ff;
   logic [23:0] s3_src_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_pix_ff <= 1'b0;
      end else if (advance) begin
         s3_pix_ff <= s2_pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_touch_ff <= s2_touch_ff;
         s3_xp_ff    <= s2_xp_ff;
         s3_yp_ff    <= s2_yp_ff;
         s3_fx_ff    <= s2_fx_ff;
         s3_fy_ff    <= s2_fy_ff;
         s3_src_ff   <= s2_src_ff;
      end
   end

   // stage 4: horizontal lerps
   logic [31:0] w00, w10, w01, w11;
   assign w00 = rd_data[{s3_yp_ff, s3_xp_ff}];
   assign w10 = rd_data[{s3_yp_ff, !s3_xp_ff}];
   assign w01 = rd_data[{!s3_yp_ff, s3_xp_ff}];
   assign w11 = rd_data[{!s3_yp_ff, !s3_xp_ff}];

   // nearest mode uses only the base texel, the neighbors may never have been loaded
   logic [3:0][7:0] t1_in, t2_in;
   for (genvar c = 0; c < 4; c++) begin : g_lerp_x
      assign t1_in[c] = interp_ff ? w00[8*c +: 8] :
                        amwb_pkg::lerp14(w00[8*c +: 8], w10[8*c +: 8], s3_fx_ff);
      assign t2_in[c] = interp_ff ? w00[8*c +: 8] :
                        amwb_pkg::lerp14(w01[8*c +: 8], w11[8*c +: 8], s3_fx_ff);
   end

   logic            s4_pix_ff, s4_touch_ff;
   logic [13:0]     s4_fy_ff;
   logic [23:0]     s4_src_ff;
   logic [3:0][7:0] s4_t1_ff, s4_t2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_pix_ff <= 1'b0;
      end else if (advance) begin
         s4_pix_ff <= s3_pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_touch_ff <= s3_touch_ff;
         s4_fy_ff    <= s3_fy_ff;
         s4_src_ff   <= s3_src_ff;
         s4_t1_ff    <= t1_in;
         s4_t2_ff    <= t2_in;
      end
   end

   // stage 5: vertical lerp
   logic [3:0][7:0] mk_in;
   for (genvar c = 0; c < 4; c++) begin : g_lerp_y
      assign mk_in[c] = amwb_pkg::lerp14(s4_t1_ff[c], s4_t2_ff[c], s4_fy_ff);
   end

   logic            s5_pix_ff, s5_touch_ff;
   logic [23:0]     s5_src_ff;
   logic [3:0][7:0] s5_mk_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_pix_ff <= 1'b0;
      end else if (advance) begin
         s5_pix_ff <= s4_pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s5_touch_ff <= s4_touch_ff;
         s5_src_ff   <= s4_src_ff;
         s5_mk_ff    <= mk_in;
      end
   end

   // stage 6: mask alpha products
   logic [2:0][15:0] sum_in;
   logic [7:0]       k;
   assign k = s5_mk_ff[3];
   for (genvar c = 0; c < 3; c++) begin : g_blend
      assign sum_in[c] = 16'(k * s5_mk_ff[c]) + 16'((8'd255 - k) * s5_src_ff[8*c +: 8]);
   end

   logic             s6_pix_ff, s6_touch_ff;
   logic [23:0]      s6_src_ff;
   logic [2:0][15:0] s6_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_pix_ff <= 1'b0;
      end else if (advance) begin
         s6_pix_ff <= s5_pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s6_touch_ff <= s5_touch_ff;
         s6_src_ff   <= s5_src_ff;
         s6_sum_ff   <= sum_in;
      end
   end

   // stage 7: divide by 255 and strength mix
   logic [7:0]  mix_a, mix_na;
   logic [23:0] out_in;
   assign mix_a  = amwb_pkg::mix_alpha(strength_ff);
   assign mix_na = 8'd128 - mix_a;

   for (genvar c = 0; c < 3; c++) begin : g_mix
      logic [16:0] q;
      logic [7:0]  m;
      logic [15:0] r;
      // exact x / 255 for 16-bit x up to 65534
      assign q = (17'(s6_sum_ff[c]) + 17'd1 + 17'(s6_sum_ff[c][15:8])) >> 8;
      assign m = q[7:0];
      assign r = 16'(mix_a * m) + 16'(mix_na * s6_src_ff[8*c +: 8]);
      assign out_in[8*c +: 8] = s6_touch_ff ? r[14:7] : s6_src_ff[8*c +: 8];
   end

   // output register
   logic        rsp_valid_ff, rsp_touch_ff;
   logic [23:0] rsp_data_ff;

   assign advance    = !(s6_pix_ff && rsp_valid_ff && !rsp_tready);
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && s6_pix_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s6_pix_ff) begin
         rsp_data_ff  <= out_in;
         rsp_touch_ff <= s6_touch_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_touch_ff;

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !s6_pix_ff |-> req_tready)
      else $error("request stalled with no pixel at the pipe end");

   a_outside_passes: assert property (@(posedge clock) disable iff (reset)
      advance && s6_pix_ff && !s6_touch_ff |=> rsp_tdata == $past(s6_src_ff) && !rsp_tuser)
      else $error("outside pixel was altered");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

// ===== verif/amwb_checker.sv =====
// checker for affine_mask_warp_blend: watches the request, result and register ports,
// predicts each blended pixel and compares it with what the block returns
// depends on amwb_pkg
`timescale 1ns / 100ps

module amwb_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [55:0] req_tdata,   // pos_x, pos_y, blue, green, red, alpha
   input  logic        req_tuser,   // kind
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // out_blue, out_green, out_red
   input  logic        rsp_tuser,   // touched
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [31:0] csr_wdata,
   output int          pending,
   output int          mismatches,
   output int          pixels_checked
);

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic       touched;
   } pixel_type;

   pixel_type          expected_pixels[$];
   logic [31:0]        mask_mem [0:amwb_pkg::MASK_WIDTH*amwb_pkg::MASK_HEIGHT-1];
   logic signed [31:0] affine [0:5];
   logic [6:0]         strength;
   logic               nearest;

   assign pending = expected_pixels.size();

   function automatic int lerp_q14(int a, int b, int f);
      longint p;
      p = longint'(f) * longint'(b - a);
      return a + int'(p >>> 14);
   endfunction

   function automatic pixel_type warp_blend(logic [11:0] px, logic [11:0] py,
                                            logic [7:0] b, logic [7:0] g, logic [7:0] r);
      longint    u, v, umax, vmax;
      int        x0, y0, base, fx, fy, k, a, m, mix, s;
      int        mk[4];
      int        src[3];
      int        t1, t2;
      bit        in_mask;
      logic [31:0] w00, w10, w01, w11;
      pixel_type res;
      umax = longint'(amwb_pkg::MASK_WIDTH - 1) * 65536;
      vmax = longint'(amwb_pkg::MASK_HEIGHT - 1) * 65536;
      u = longint'(affine[0]) * longint'(px) + longint'(affine[1]) * longint'(py)
          + longint'(affine[2]);
      v = longint'(affine[3]) * longint'(px) + longint'(affine[4]) * longint'(py)
          + longint'(affine[5]);
      if (nearest)
         in_mask = u >= 65536 && u < umax && v >= 65536 && v < vmax;
      else
         in_mask = u > 0 && u < umax && v > 0 && v < vmax;
      res.blue = b;
      res.green = g;
      res.red = r;
      res.touched = 1'b0;
      if (!in_mask) return res;
      x0 = int'(u >>> 16);
      y0 = int'(v >>> 16);
      if (x0 > amwb_pkg::MASK_WIDTH - 2) x0 = amwb_pkg::MASK_WIDTH - 2;
      if (y0 > amwb_pkg::MASK_HEIGHT - 2) y0 = amwb_pkg::MASK_HEIGHT - 2;
      base = y0 * amwb_pkg::MASK_WIDTH + x0;
      w00 = mask_mem[base];
      w10 = mask_mem[base + 1];
      w01 = mask_mem[base + amwb_pkg::MASK_WIDTH];
      w11 = mask_mem[base + amwb_pkg::MASK_WIDTH + 1];
      fx = int'(u & 64'hFFFF) >> 2;
      fy = int'(v & 64'hFFFF) >> 2;
      for (int c = 0; c < 4; c++) begin
         if (nearest) begin
            mk[c] = int'(w00[8*c +: 8]);
         end else begin
            t1 = lerp_q14(int'(w00[8*c +: 8]), int'(w10[8*c +: 8]), fx);
            t2 = lerp_q14(int'(w01[8*c +: 8]), int'(w11[8*c +: 8]), fx);
            mk[c] = lerp_q14(t1, t2, fy);
         end
      end
      src[0] = int'(b);
      src[1] = int'(g);
      src[2] = int'(r);
      s = (strength > 7'd100) ? 100 : int'(strength);
      a = 128 * s / 100;
      k = mk[3];
      for (int c = 0; c < 3; c++) begin
         m = (k * mk[c] + (255 - k) * src[c]) / 255;
         mix = a * m + (128 - a) * src[c];
         src[c] = (mix >> 7) & 255;
      end
      res.blue = src[0][7:0];
      res.green = src[1][7:0];
      res.red = src[2][7:0];
      res.touched = 1'b1;
      return res;
   endfunction

   always @(posedge clock) begin
      pixel_type want;
      if (reset) begin
         expected_pixels.delete();
         affine[0] = 32'sd65536;
         affine[1] = 32'sd0;
         affine[2] = 32'sd0;
         affine[3] = 32'sd0;
         affine[4] = 32'sd65536;
         affine[5] = 32'sd0;
         strength = 7'd100;
         nearest = 1'b0;
         mismatches = 0;
         pixels_checked = 0;
      end else begin
         if (csr_we) begin
            if (csr_addr == amwb_pkg::CSR_STRENGTH)
               strength = csr_wdata[6:0];
            else if (csr_addr == amwb_pkg::CSR_INTERP)
               nearest = csr_wdata[0];
            else
               affine[csr_addr] = csr_wdata;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               $error("result with no pixel pending: tdata %h tuser %b", rsp_tdata, rsp_tuser);
               mismatches++;
            end else begin
               want = expected_pixels.pop_front();
               pixels_checked++;
               if (rsp_tdata[7:0] !== want.blue) begin
                  $error("out_blue expected %0d actual %0d", want.blue, rsp_tdata[7:0]);
                  mismatches++;
               end
               if (rsp_tdata[15:8] !== want.green) begin
                  $error("out_green expected %0d actual %0d", want.green, rsp_tdata[15:8]);
                  mismatches++;
               end
               if (rsp_tdata[23:16] !== want.red) begin
                  $error("out_red expected %0d actual %0d", want.red, rsp_tdata[23:16]);
                  mismatches++;
               end
               if (rsp_tuser !== want.touched) begin
                  $error("touched expected %0d actual %0d", want.touched, rsp_tuser);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser) begin
               expected_pixels.push_back(warp_blend(req_tdata[11:0], req_tdata[23:12],
                                                    req_tdata[31:24], req_tdata[39:32],
                                                    req_tdata[47:40]));
            end else if (req_tdata[11:0] < amwb_pkg::MASK_WIDTH &&
                         req_tdata[23:12] < amwb_pkg::MASK_HEIGHT) begin
               mask_mem[int'(req_tdata[23:12]) * amwb_pkg::MASK_WIDTH
                        + int'(req_tdata[11:0])] = req_tdata[55:24];
            end
         end
      end
   end

endmodule

// ===== verif/tb.sv =====
// testbench top for affine_mask_warp_blend: drives mask loads, pixels and register
// settings with random gaps and stalls; checking is done in amwb_checker
// depends on amwb_pkg, amwb_checker and the block itself
`timescale 1ns / 100ps

module tb;

   localparam int IDLE_LIMIT = 4000;
   localparam int SETTLE     = 16;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;   // pos_x, pos_y, blue, green, red, alpha
   logic        req_tuser;   // kind
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // out_blue, out_green, out_red
   logic        rsp_tuser;   // touched
   logic        csr_we;
   logic [2:0]  csr_addr;
   logic [31:0] csr_wdata;
   int          pending, mismatches, pixels_checked;

   // texels written so far; pixels are only sent when every texel they sample is here
   bit                 loaded [0:amwb_pkg::MASK_WIDTH*amwb_pkg::MASK_HEIGHT-1];
   logic signed [31:0] map_coef [0:5];
   logic               map_nearest;
   int                 burst_left, gap_left, idle_cycles, ready_cycle, stall_left;
   int                 loads_sent, pixels_sent, settings_used;

   affine_mask_warp_blend dut (.*);

   amwb_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // receiver: always ready, coin flips, then long stalls, in turn
   always @(posedge clock) begin
      ready_cycle <= ready_cycle + 1;
      case ((ready_cycle / 300) % 3)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         default: begin
            if (stall_left > 0) begin
               stall_left <= stall_left - 1;
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
               if ($urandom_range(0, 3) == 0) stall_left <= $urandom_range(1, 12);
            end
         end
      endcase
   end

   task automatic send_request(logic kind, logic [11:0] px, logic [11:0] py,
                               logic [31:0] bgra);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
      while (gap_left > 0) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         gap_left--;
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {bgra, py, px};
      @(posedge clock iff req_tready);
      burst_left--;
      if (kind) begin
         pixels_sent++;
      end else begin
         loads_sent++;
         if (px < amwb_pkg::MASK_WIDTH && py < amwb_pkg::MASK_HEIGHT)
            loaded[int'(py) * amwb_pkg::MASK_WIDTH + int'(px)] = 1'b1;
      end
   endtask

   task automatic load_texel(int px, int py);
      logic [31:0] bgra;
      bgra = $urandom;
      case ($urandom_range(0, 7))
         0: bgra[31:24] = 8'd0;
         1: bgra[31:24] = 8'd255;
         2: bgra = 32'hFFFF_FFFF;
         3: bgra = 32'h0000_0000;
         default: ;
      endcase
      send_request(1'b0, px[11:0], py[11:0], bgra);
   endtask

   // waits for the pipeline to drain, then writes every register
   task automatic apply_settings(logic [31:0] ux, logic [31:0] uy, logic [31:0] ou,
                                 logic [31:0] vx, logic [31:0] vy, logic [31:0] ov,
                                 logic [6:0] strength, logic nearest);
      logic [31:0] vals [0:7];
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      vals = '{ux, uy, ou, vx, vy, ov, {25'd0, strength}, {31'd0, nearest}};
      for (int i = 0; i < 8; i++) begin
         csr_we <= 1'b1;
         csr_addr <= amwb_pkg::csr_index_type'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      for (int i = 0; i < 6; i++) map_coef[i] = vals[i];
      map_nearest = nearest;
      settings_used++;
   endtask

   function automatic bit texels_ready(logic [11:0] px, logic [11:0] py);
      longint u, v, umax, vmax;
      int     base;
      umax = longint'(amwb_pkg::MASK_WIDTH - 1) * 65536;
      vmax = longint'(amwb_pkg::MASK_HEIGHT - 1) * 65536;
      u = longint'(map_coef[0]) * longint'(px) + longint'(map_coef[1]) * longint'(py)
          + longint'(map_coef[2]);
      v = longint'(map_coef[3]) * longint'(px) + longint'(map_coef[4]) * longint'(py)
          + longint'(map_coef[5]);
      if (map_nearest) begin
         if (!(u >= 65536 && u < umax && v >= 65536 && v < vmax)) return 1;
      end else if (!(u > 0 && u < umax && v > 0 && v < vmax)) begin
         return 1;
      end
      base = int'(v >>> 16) * amwb_pkg::MASK_WIDTH + int'(u >>> 16);
      if (map_nearest) return loaded[base];
      return loaded[base] && loaded[base + 1] && loaded[base + amwb_pkg::MASK_WIDTH]
             && loaded[base + amwb_pkg::MASK_WIDTH + 1];
   endfunction

   task automatic send_pixel(int px, int py, logic [23:0] bgr);
      send_request(1'b1, px[11:0], py[11:0], {8'($urandom), bgr});
   endtask

   task automatic random_pixels(int count);
      logic [11:0] px, py;
      bit          found;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 9) == 0) begin
            load_texel($urandom_range(0, 4095), $urandom_range(0, 4095));
         end else if ($urandom_range(0, 12) == 0) begin
            load_texel($urandom_range(0, 23), $urandom_range(0, 23));
         end
         found = 0;
         for (int t = 0; t < 30 && !found; t++) begin
            if ($urandom_range(0, 9) == 0) begin
               px = 12'($urandom_range(0, 4095));
               py = 12'($urandom_range(0, 4095));
            end else begin
               px = 12'($urandom_range(0, 40));
               py = 12'($urandom_range(0, 40));
            end
            found = texels_ready(px, py);
         end
         if (found) send_pixel(int'(px), int'(py), 24'($urandom));
      end
   endtask

   function automatic logic [31:0] rand_coef(int mag);
      int c;
      c = $urandom_range(0, mag);
      return ($urandom_range(0, 1) != 0) ? 32'(-c) : 32'(c);
   endfunction

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_addr = amwb_pkg::CSR_COEF_UX;
      csr_wdata = '0;
      ready_cycle = 0;
      stall_left = 0;
      idle_cycles = 0;
      burst_left = 0;
      gap_left = 0;
      loads_sent = 0;
      pixels_sent = 0;
      settings_used = 0;
      map_coef = '{32'sd65536, 0, 0, 0, 32'sd65536, 0};
      map_nearest = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset map, pixels at the mask edges, loads off the mask and at its far corner
      send_pixel(0, 0, 24'hFFFFFF);
      send_pixel(4095, 4095, 24'h000000);
      send_pixel(255, 1, 24'h123456);
      load_texel(4095, 4095);
      load_texel(256, 3);
      load_texel(3, 256);
      for (int y = 252; y < 256; y++)
         for (int x = 252; x < 256; x++) load_texel(x, y);
      send_pixel(254, 254, 24'hFF00FF);
      send_pixel(254, 253, 24'h00FF00);

      // well-formed mask: a window at the origin
      for (int y = 0; y < 20; y++)
         for (int x = 0; x < 20; x++) load_texel(x, y);
      send_pixel(1, 1, 24'h000000);
      send_pixel(18, 18, 24'hFFFFFF);
      send_pixel(5, 9, 24'h80FF00);
      random_pixels(30);

      apply_settings(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 7'd100, 1'b0);
      random_pixels(30);
      apply_settings(32'h0000_C000, 32'h0000_2000, 32'h0000_4321, 32'hFFFF_F000,
                     32'h0001_0800, 32'h0002_0000, 7'd50, 1'b1);
      send_pixel(0, 0, 24'hFFFFFF);
      send_pixel(1, 1, 24'h000000);
      random_pixels(50);
      apply_settings(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'h8000_0000, 7'd127, 1'b0);
      send_pixel(0, 0, 24'h00FF00);
      send_pixel(4095, 4095, 24'hFF00FF);
      random_pixels(20);
      apply_settings(32'h0001_0000, 32'h0, 32'h0000_8000, 32'h0, 32'h0001_0000,
                     32'h0000_4000, 7'd0, 1'b0);
      random_pixels(30);
      for (int p = 0; p < 4; p++) begin
         apply_settings(rand_coef(131072), rand_coef(32768), $urandom_range(0, 20 << 16),
                        rand_coef(32768), rand_coef(131072), $urandom_range(0, 20 << 16),
                        7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
         random_pixels(50);
      end

      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      $display("covered %0d mask loads and %0d pixels (%0d checked) over %0d register settings",
               loads_sent, pixels_sent, pixels_checked, settings_used);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ===== affine_mask_warp_blend.f =====
rtl/amwb_pkg.sv
rtl/amwb_mask_ram.sv
rtl/affine_mask_warp_blend.sv
verif/amwb_checker.sv
verif/tb.sv
